### rtl/assert_macros.svh
// Assertion macros used by the checker file ptqm_checks.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### rtl/ptqm_pkg.sv
// Package for the priority task queue manager: status codes, operations and beat types.
// No dependencies.
`timescale 1ns / 1ps
package ptqm_pkg;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEVEL = 3'd1;
  localparam logic [2:0] ST_BAD_ARGS  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic        op;
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [3:0]  level;
    logic [31:0] handler;
    logic [3:0]  arg_count;
    logic [63:0] deadline;
    logic [3:0]  compare_level;
  } cmd_t;
endpackage

### rtl/ptqm_front.sv
// Front part: accept command beats, check operands, push to the command queue.
// Depends on ptqm_pkg.
`timescale 1ns / 1ps
module ptqm_front #(
  parameter int PRIORITY_LEVELS = 4,
  parameter int MAX_ARG_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             op,
  input  logic [1:0]       task_kind,
  input  logic [3:0]       level,
  input  logic [31:0]      handler_handle,
  input  logic [3:0]       arg_count,
  input  logic [63:0]      deadline,
  input  logic [3:0]       compare_level,
  output logic             push,
  output ptqm_pkg::cmd_t   cmd
);
  ptqm_pkg::cmd_t c;
  always_comb begin
    c.op = op;
    c.kind = task_kind;
    c.level = level;
    c.handler = handler_handle;
    c.arg_count = arg_count;
    c.deadline = deadline;
    c.compare_level = compare_level;
    c.status = ptqm_pkg::ST_OK;
    if (op == ptqm_pkg::OP_ENQ) begin
      if (32'(level) >= PRIORITY_LEVELS) c.status = ptqm_pkg::ST_BAD_LEVEL;
      else if (32'(arg_count) > MAX_ARG_COUNT) c.status = ptqm_pkg::ST_BAD_ARGS;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= start && !busy;
    end
    cmd <= c;
  end
endmodule

### rtl/ptqm_fifo.sv
// Two-entry command queue between front and back parts.
// Depends on ptqm_pkg.
`timescale 1ns / 1ps
module ptqm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ptqm_pkg::cmd_t wdata,
  input  logic           pop,
  output logic           not_empty,
  output ptqm_pkg::cmd_t rdata,
  output logic [1:0]     count
);
  ptqm_pkg::cmd_t mem [2];
  logic wp, rp;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wp] <= wdata;
  end
  assign rdata = mem[rp];
  assign not_empty = count != 2'd0;
endmodule

### rtl/ptqm_back.sv
// Back part: carry out enqueue and dequeue on the linked lists, taking a command in S_IDLE and applying it in S_EXEC.
// Depends on ptqm_pkg.
`timescale 1ns / 1ps
module ptqm_back #(
  parameter int POOL_SLOTS = 16,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  ptqm_pkg::cmd_t cmd,
  output logic           pop,
  output logic           done,
  output logic [2:0]     status,
  output logic [1:0]     out_kind,
  output logic [3:0]     out_level,
  output logic [31:0]    out_handler,
  output logic [3:0]     out_arg_count,
  output logic [63:0]    out_deadline,
  output logic           pending_any,
  output logic           higher_waiting
);
  localparam int SW = $clog2(POOL_SLOTS + 1);
  localparam int LW = $clog2(PRIORITY_LEVELS);
  localparam logic [SW-1:0] NIL = SW'(POOL_SLOTS);

  typedef enum logic {S_IDLE, S_EXEC} state_t;
  state_t state;

  logic [41:0]   slot_info [POOL_SLOTS];
  logic [63:0]   slot_deadline [POOL_SLOTS];
  logic [SW-1:0] slot_link [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] link_init;
  logic [SW-1:0] free_head;
  logic [SW-1:0] qhead [PRIORITY_LEVELS];
  logic [SW-1:0] qtail [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] nonempty, nonempty_next;

  ptqm_pkg::cmd_t c;
  logic [SW-1:0] slot;
  logic [SW-1:0] rd_link;
  logic          found;
  logic [LW-1:0] deq_lvl;
  logic [LW-1:0] enq_lvl;
  logic [LW-1:0] enq_l;

  always_comb begin
    found = 1'b0;
    deq_lvl = '0;
    for (int p = PRIORITY_LEVELS - 1; p >= 0; p--) begin
      if (nonempty[p]) begin
        found = 1'b1;
        deq_lvl = LW'(p);
      end
    end
  end
  assign enq_lvl = cmd.level[LW-1:0];

  function automatic logic hw(logic [PRIORITY_LEVELS-1:0] ne, logic [3:0] cl);
    logic r;
    r = 1'b0;
    for (int p = 0; p < PRIORITY_LEVELS; p++)
      if (ne[p] && 32'(cl) > p) r = 1'b1;
    return r;
  endfunction

  always_comb begin
    rd_link = slot_link[slot[SW-1:0] == NIL ? '0 : slot[$clog2(POOL_SLOTS)-1:0]];
    if (slot != NIL && !link_init[slot[$clog2(POOL_SLOTS)-1:0]])
      rd_link = (32'(slot) + 1 < POOL_SLOTS) ? SW'(32'(slot) + 1) : NIL;
  end

  always_comb begin
    nonempty_next = nonempty;
    if (c.op == ptqm_pkg::OP_DEQ) begin
      if (slot != NIL && (rd_link == NIL || qtail[enq_l] == slot))
        nonempty_next[enq_l] = 1'b0;
    end else if (c.status == ptqm_pkg::ST_OK && slot != NIL) begin
      nonempty_next[enq_l] = 1'b1;
    end
  end

  assign pop = avail && state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      free_head <= '0;
      nonempty <= '0;
      link_init <= '0;
    end else begin
      done <= state == S_EXEC;
      case (state)
        S_IDLE: begin
          if (avail) begin
            c <= cmd;
            state <= S_EXEC;
            if (cmd.op == ptqm_pkg::OP_DEQ) slot <= found ? qhead[deq_lvl] : NIL;
            else slot <= free_head;
            enq_l <= cmd.op == ptqm_pkg::OP_DEQ ? deq_lvl : enq_lvl;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          if (c.op == ptqm_pkg::OP_DEQ && slot != NIL) begin
            status <= ptqm_pkg::ST_OK;
            {out_kind, out_level, out_arg_count, out_handler} <=
              slot_info[slot[$clog2(POOL_SLOTS)-1:0]];
            out_deadline <= slot_deadline[slot[$clog2(POOL_SLOTS)-1:0]];
            qhead[enq_l] <= rd_link;
            slot_link[slot[$clog2(POOL_SLOTS)-1:0]] <= free_head;
            link_init[slot[$clog2(POOL_SLOTS)-1:0]] <= 1'b1;
            free_head <= slot;
          end else begin
            out_kind <= '0;
            out_level <= '0;
            out_handler <= '0;
            out_arg_count <= '0;
            out_deadline <= '0;
            if (c.op == ptqm_pkg::OP_DEQ) begin
              status <= ptqm_pkg::ST_EMPTY;
            end else if (c.status != ptqm_pkg::ST_OK) begin
              status <= c.status;
            end else if (slot == NIL) begin
              status <= ptqm_pkg::ST_FULL;
            end else begin
              status <= ptqm_pkg::ST_OK;
              free_head <= rd_link;
              slot_info[slot[$clog2(POOL_SLOTS)-1:0]] <=
                {c.kind, c.level, c.arg_count, c.handler};
              slot_deadline[slot[$clog2(POOL_SLOTS)-1:0]] <= c.deadline;
              slot_link[slot[$clog2(POOL_SLOTS)-1:0]] <= NIL;
              link_init[slot[$clog2(POOL_SLOTS)-1:0]] <= 1'b1;
              if (!nonempty[enq_l]) qhead[enq_l] <= slot;
              else slot_link[qtail[enq_l][$clog2(POOL_SLOTS)-1:0]] <= slot;
              qtail[enq_l] <= slot;
            end
          end
          nonempty <= nonempty_next;
          pending_any <= |nonempty_next;
          higher_waiting <= hw(nonempty_next, c.compare_level);
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/priority_task_queue_manager_top.sv
// Top level of the priority task queue manager.
// Depends on ptqm_pkg, ptqm_front, ptqm_fifo, ptqm_back.
//
// Usage:
//  - Command channel: raise start with op and operands; the beat is taken at
//    a rising edge where start is high and busy is low.
//  - Result channel: done strobes for one cycle with status, descriptor,
//    pending_any and higher_waiting. The receiver cannot stall it.
//  - Path: a command passes the front register, the queue write, the back-end
//    read state, then the rewrite state, which raises done.
//  - The back part takes a new command only once the link read-modify-write
//    of the current one is through; the command queue holds those behind it.
//  - busy holds while the command queue is near full.
//  - Reset (rst, synchronous) chains all slots onto the free list and empties
//    every level; it takes effect at once, no sweep.
//  - Results come out in command order.
`timescale 1ns / 1ps
module priority_task_queue_manager_top #(
  parameter int POOL_SLOTS = 16,
  parameter int PRIORITY_LEVELS = 4,
  parameter int MAX_ARG_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [1:0]  task_kind,
  input  logic [3:0]  level,
  input  logic [31:0] handler_handle,
  input  logic [3:0]  arg_count,
  input  logic [63:0] deadline,
  input  logic [3:0]  compare_level,
  output logic        done,
  output logic [2:0]  status,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_level,
  output logic [31:0] out_handler,
  output logic [3:0]  out_arg_count,
  output logic [63:0] out_deadline,
  output logic        pending_any,
  output logic        higher_waiting
);
  logic push, pop, not_empty;
  logic [1:0] count;
  ptqm_pkg::cmd_t fcmd, qcmd;

  assign busy = (count + {1'b0, push}) >= 2'd2 || (push && count != 2'd0);

  ptqm_front #(.PRIORITY_LEVELS(PRIORITY_LEVELS), .MAX_ARG_COUNT(MAX_ARG_COUNT)) u_front (
    .clk, .rst, .start, .busy, .op, .task_kind, .level, .handler_handle,
    .arg_count, .deadline, .compare_level, .push, .cmd(fcmd));

  ptqm_fifo u_fifo (.clk, .rst, .push, .wdata(fcmd), .pop, .not_empty,
    .rdata(qcmd), .count);

  ptqm_back #(.POOL_SLOTS(POOL_SLOTS), .PRIORITY_LEVELS(PRIORITY_LEVELS)) u_back (
    .clk, .rst, .avail(not_empty), .cmd(qcmd), .pop, .done, .status, .out_kind,
    .out_level, .out_handler, .out_arg_count, .out_deadline, .pending_any,
    .higher_waiting);
endmodule

### rtl/ptqm_checks.sv
// Port-level checks for the priority task queue manager, bound to the top level.
// Depends on assert_macros.svh and ptqm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptqm_checks (
  input logic       clk,
  input logic       rst,
  input logic       done,
  input logic [2:0] status,
  input logic [1:0] out_kind,
  input logic [63:0] out_deadline,
  input logic       pending_any,
  input logic       higher_waiting
);
  `CHK_IMPLY(a_status_range, clk, rst, done, status <= ptqm_pkg::ST_EMPTY)
  `CHK_IMPLY(a_higher_pending, clk, rst, done && higher_waiting, pending_any)
  `CHK_IMPLY(a_empty_none, clk, rst, done && status == ptqm_pkg::ST_EMPTY, !pending_any)
  `CHK_NEXT(a_done_pulse, clk, rst, done, !done)
  `CHK_IMPLY(a_fail_zero, clk, rst, done && status != ptqm_pkg::ST_OK, out_kind == 2'd0 && out_deadline == 64'd0)
endmodule

bind priority_task_queue_manager_top ptqm_checks u_checks (
  .clk, .rst, .done, .status, .out_kind, .out_deadline, .pending_any,
  .higher_waiting);

### tb/tb_priority_task_queue_manager_top.sv
// Self-checking testbench for priority_task_queue_manager_top: directed table then random
// enqueue/dequeue traffic, every done beat checked against a behavioural queue predictor.
// Depends on ptqm_pkg and the priority_task_queue_manager_top RTL.
`timescale 1ns / 1ps
module tb_priority_task_queue_manager_top;
  localparam int NSLOT = 16;
  localparam int NLVL = 4;
  localparam int MAXARG = 8;
  localparam int NIL = NSLOT;

  typedef struct {
    logic        op;
    logic [1:0]  kind;
    logic [3:0]  lvl;
    logic [31:0] hnd;
    logic [3:0]  argc;
    logic [63:0] dl;
    logic [3:0]  cmp;
    logic        fixed;
    logic [2:0]  st;
  } row_t;

  typedef struct {
    logic [2:0]  st;
    logic [1:0]  kind;
    logic [3:0]  lvl;
    logic [31:0] hnd;
    logic [3:0]  argc;
    logic [63:0] dl;
    logic        pend;
    logic        higher;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = 1'b0;
  logic [1:0] task_kind = '0;
  logic [3:0] level = '0;
  logic [31:0] handler_handle = '0;
  logic [3:0] arg_count = '0;
  logic [63:0] deadline = '0;
  logic [3:0] compare_level = '0;
  logic busy, done, pending_any, higher_waiting;
  logic [2:0] status;
  logic [1:0] out_kind;
  logic [3:0] out_level, out_arg_count;
  logic [31:0] out_handler;
  logic [63:0] out_deadline;

  res_t expected_q[$];
  int errors = 0;

  logic [1:0]  s_kind[NSLOT];
  logic [3:0]  s_lvl[NSLOT];
  logic [31:0] s_hnd[NSLOT];
  logic [3:0]  s_argc[NSLOT];
  logic [63:0] s_dl[NSLOT];
  int s_link[NSLOT];
  int free_hd;
  int q_hd[NLVL];
  int q_tl[NLVL];

  always #1 clk = ~clk;

  priority_task_queue_manager_top u_dut (.*);

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_reset();
    for (int i = 0; i < NSLOT; i++) s_link[i] = i + 1;
    free_hd = 0;
    for (int i = 0; i < NLVL; i++) begin
      q_hd[i] = NIL;
      q_tl[i] = NIL;
    end
  endtask

  function automatic logic waiting_below(input int lim);
    int l;
    l = lim > NLVL ? NLVL : lim;
    for (int p = 0; p < l; p++) if (q_hd[p] != NIL) return 1'b1;
    return 1'b0;
  endfunction

  task automatic queue_step(input row_t r, output res_t e);
    int s;
    e = '{default: '0};
    if (r.op == ptqm_pkg::OP_ENQ) begin
      if (r.lvl >= NLVL) e.st = ptqm_pkg::ST_BAD_LEVEL;
      else if (r.argc > MAXARG) e.st = ptqm_pkg::ST_BAD_ARGS;
      else if (free_hd == NIL) e.st = ptqm_pkg::ST_FULL;
      else begin
        s = free_hd;
        free_hd = s_link[s];
        s_kind[s] = r.kind; s_lvl[s] = r.lvl; s_hnd[s] = r.hnd;
        s_argc[s] = r.argc; s_dl[s] = r.dl;
        s_link[s] = NIL;
        if (q_hd[r.lvl] == NIL) q_hd[r.lvl] = s;
        else s_link[q_tl[r.lvl]] = s;
        q_tl[r.lvl] = s;
        e.st = ptqm_pkg::ST_OK;
      end
    end else begin
      e.st = ptqm_pkg::ST_EMPTY;
      for (int p = 0; p < NLVL; p++) begin
        if (q_hd[p] != NIL) begin
          s = q_hd[p];
          q_hd[p] = s_link[s];
          if (q_hd[p] == NIL) q_tl[p] = NIL;
          e.kind = s_kind[s]; e.lvl = s_lvl[s]; e.hnd = s_hnd[s];
          e.argc = s_argc[s]; e.dl = s_dl[s];
          s_link[s] = free_hd;
          free_hd = s;
          e.st = ptqm_pkg::ST_OK;
          break;
        end
      end
    end
    e.pend = waiting_below(NLVL);
    e.higher = (r.cmp != 0) && waiting_below(r.cmp);
  endtask

  task automatic send(input row_t r, input bit gaps);
    res_t e;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op; task_kind <= r.kind; level <= r.lvl; handler_handle <= r.hnd;
    arg_count <= r.argc; deadline <= r.dl; compare_level <= r.cmp;
    @(posedge clk);
    while (busy) @(posedge clk);
    queue_step(r, e);
    if (r.fixed && e.st != r.st) report("table status", 64'(e.st), 64'(r.st));
    expected_q.push_back(e);
  endtask

  function automatic row_t rand_row(input int deq_pct);
    row_t r;
    r.op = ($urandom_range(0, 99) < deq_pct) ? ptqm_pkg::OP_DEQ : ptqm_pkg::OP_ENQ;
    r.kind = 2'($urandom_range(0, 3));
    r.lvl = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                           : $urandom_range(0, NLVL - 1));
    r.hnd = $urandom;
    r.argc = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                            : $urandom_range(0, MAXARG));
    r.dl = {$urandom, $urandom};
    r.cmp = 4'($urandom_range(0, 15));
    r.fixed = 1'b0;
    r.st = ptqm_pkg::ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", 64'(status), 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st) report("status", 64'(status), 64'(e.st));
        if (out_kind !== e.kind) report("out_kind", 64'(out_kind), 64'(e.kind));
        if (out_level !== e.lvl) report("out_level", 64'(out_level), 64'(e.lvl));
        if (out_handler !== e.hnd) report("out_handler", 64'(out_handler), 64'(e.hnd));
        if (out_arg_count !== e.argc)
          report("out_arg_count", 64'(out_arg_count), 64'(e.argc));
        if (out_deadline !== e.dl) report("out_deadline", out_deadline, e.dl);
        if (pending_any !== e.pend) report("pending_any", 64'(pending_any), 64'(e.pend));
        if (higher_waiting !== e.higher)
          report("higher_waiting", 64'(higher_waiting), 64'(e.higher));
      end
    end
  end

  initial begin
    #200000;
    $display("priority_task_queue_manager_top verification failed");
    $finish;
  end

  initial begin
    row_t tbl[$];
    row_t r;
    int n;
    queue_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tbl.push_back('{ptqm_pkg::OP_DEQ, 2'd0, 4'd0, 32'h0, 4'd0, 64'h0, 4'd0,
                    1'b1, ptqm_pkg::ST_EMPTY});
    tbl.push_back('{ptqm_pkg::OP_ENQ, 2'd3, 4'd4, 32'hFFFFFFFF, 4'd0, 64'h0, 4'd15,
                    1'b1, ptqm_pkg::ST_BAD_LEVEL});
    tbl.push_back('{ptqm_pkg::OP_ENQ, 2'd1, 4'd15, 32'h1, 4'd15, 64'h1, 4'd1,
                    1'b1, ptqm_pkg::ST_BAD_LEVEL});
    tbl.push_back('{ptqm_pkg::OP_ENQ, 2'd2, 4'd3, 32'h5, 4'd9, 64'h5, 4'd2,
                    1'b1, ptqm_pkg::ST_BAD_ARGS});
    tbl.push_back('{ptqm_pkg::OP_ENQ, 2'd3, 4'd3, 32'hFFFFFFFF, 4'd8, 64'hFFFFFFFFFFFFFFFF,
                    4'd3, 1'b1, ptqm_pkg::ST_OK});
    tbl.push_back('{ptqm_pkg::OP_ENQ, 2'd0, 4'd0, 32'h0, 4'd0, 64'h0, 4'd0,
                    1'b1, ptqm_pkg::ST_OK});
    tbl.push_back('{ptqm_pkg::OP_ENQ, 2'd1, 4'd1, 32'hA5A5A5A5, 4'd4, 64'h5A5A5A5A5A5A5A5A,
                    4'd15, 1'b0, ptqm_pkg::ST_OK});
    tbl.push_back('{ptqm_pkg::OP_DEQ, 2'd0, 4'd0, 32'h0, 4'd0, 64'h0, 4'd1,
                    1'b0, ptqm_pkg::ST_OK});
    tbl.push_back('{ptqm_pkg::OP_DEQ, 2'd0, 4'd0, 32'h0, 4'd0, 64'h0, 4'd4,
                    1'b0, ptqm_pkg::ST_OK});
    tbl.push_back('{ptqm_pkg::OP_DEQ, 2'd0, 4'd0, 32'h0, 4'd0, 64'h0, 4'd15,
                    1'b0, ptqm_pkg::ST_OK});
    tbl.push_back('{ptqm_pkg::OP_DEQ, 2'd0, 4'd0, 32'h0, 4'd0, 64'h0, 4'd15,
                    1'b1, ptqm_pkg::ST_EMPTY});
    foreach (tbl[i]) send(tbl[i], 1'b0);

    // fill the pool and overflow it, then drain past empty
    for (int i = 0; i < NSLOT + 2; i++) begin
      r = rand_row(0);
      r.lvl = 4'(i % NLVL); r.argc = 4'(i % (MAXARG + 1));
      send(r, 1'b1);
    end
    for (int i = 0; i < NSLOT + 2; i++) send(rand_row(100), 1'b1);

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    for (n = 0; n < 1100; n++) begin
      r = rand_row((n / 150) % 2 == 0 ? 35 : 65);
      send(r, n < 950);
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("priority_task_queue_manager_top verification clean");
    end else begin
      $display("priority_task_queue_manager_top verification failed");
    end
    $finish;
  end
endmodule
